/* hw/rtl/depth_to_space_pad_address_map_macros.svh */
// Assertion macros shared by the address map RTL.
// Each macro expects clk and rst in scope.
`ifndef DEPTH_TO_SPACE_PAD_ADDRESS_MAP_MACROS_SVH
`define DEPTH_TO_SPACE_PAD_ADDRESS_MAP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define D2S_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define D2S_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/d2s_pkg.sv */
// ----------------------------------------------------------------------------
// d2s_pkg
// Shared widths and register indexes of the depth-to-space address map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package d2s_pkg;

  // Datapath and divider width, slice, register index and configuration widths
  localparam int DIV_W   = 32;
  localparam int SLICE_W = 9;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 13;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_FRAMES_IN = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROWS_IN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_COLS_IN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_FACTOR_T  = 3'd3;
  localparam logic [IDX_W-1:0] REG_FACTOR_H  = 3'd4;
  localparam logic [IDX_W-1:0] REG_FACTOR_W  = 3'd5;
  localparam logic [IDX_W-1:0] REG_PAD_ROWS  = 3'd6;
  localparam logic [IDX_W-1:0] REG_PAD_COLS  = 3'd7;

endpackage

/* hw/rtl/depth_to_space_pad_address_map.sv */
// Pipeline of 102 register stages from the edge that accepts an input beat to
// out_valid. Throughput: one beat per cycle while in_stall is low; three layers of 32-cell
// divider rows, one quotient bit per cell, set the depth.
// A two-entry output (register plus skid) keeps input flowing for one
// beat while the output is stalled.
// Reset (rst, synchronous, active high) clears all valids and loads register defaults.
// ----------------------------------------------------------------------------
// depth_to_space_pad_address_map
// Maps an output interior stick index to source page, slice and padded page.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "depth_to_space_pad_address_map_macros.svh"

module depth_to_space_pad_address_map
  import d2s_pkg::*;
#(
  parameter int SKIP_FIRST_FRAME = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DIV_W-1:0]   stick_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DIV_W-1:0]   source_page,
  output logic [SLICE_W-1:0] slice_index,
  output logic [DIV_W-1:0]   dest_page
);

  localparam logic [DIV_W-1:0] SKIP_W = DIV_W'(SKIP_FIRST_FRAME);

  logic [10:0] frames_in;
  logic [12:0] rows_in;
  logic [12:0] cols_in;
  logic [3:0]  factor_t;
  logic [3:0]  factor_h;
  logic [3:0]  factor_w;
  logic [6:0]  pad_rows;
  logic [6:0]  pad_cols;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in <= 11'd1;
      rows_in   <= 13'd1;
      cols_in   <= 13'd1;
      factor_t  <= 4'd1;
      factor_h  <= 4'd1;
      factor_w  <= 4'd1;
      pad_rows  <= 7'd0;
      pad_cols  <= 7'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAMES_IN: frames_in <= cfg_data[10:0];
        REG_ROWS_IN:   rows_in   <= cfg_data[12:0];
        REG_COLS_IN:   cols_in   <= cfg_data[12:0];
        REG_FACTOR_T:  factor_t  <= cfg_data[3:0];
        REG_FACTOR_H:  factor_h  <= cfg_data[3:0];
        REG_FACTOR_W:  factor_w  <= cfg_data[3:0];
        REG_PAD_ROWS:  pad_rows  <= cfg_data[6:0];
        REG_PAD_COLS:  pad_cols  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Derived sizes, registered from the configuration; area also goes through rows_int and cols_int
  logic [16:0]      rows_int;
  logic [16:0]      cols_int;
  logic [17:0]      rows_pad;
  logic [17:0]      cols_pad;
  logic [DIV_W-1:0] frames_out;
  logic [DIV_W-1:0] area;
  logic [DIV_W-1:0] frame_pages;

  always_ff @(posedge clk) begin
    rows_int    <= 17'(rows_in * factor_h);
    cols_int    <= 17'(cols_in * factor_w);
    rows_pad    <= 18'(18'(rows_in * factor_h) + {10'd0, pad_rows, 1'b0});
    cols_pad    <= 18'(18'(cols_in * factor_w) + {10'd0, pad_cols, 1'b0});
    frames_out  <= {17'd0, 15'(frames_in * factor_t)} - SKIP_W;
    area        <= DIV_W'({15'd0, rows_int} * {15'd0, cols_int});
    frame_pages <= DIV_W'({14'd0, rows_pad} * {14'd0, cols_pad});
  end

  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // Two lead stages let derived sizes settle after a register write
  logic             v0, v1;
  logic [DIV_W-1:0] idx0, idx1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx0 <= stick_index;
      idx1 <= idx0;
    end
  end

  // Layer 1: global frame and in-frame offset
  logic             d1_valid;
  logic [DIV_W-1:0] frame_g1, rem1;

  d2s_div_chain #(.SW(1)) u_div_frame (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v1), .dividend(idx1), .divisor(area), .in_side(1'b0),
    .out_valid(d1_valid), .quotient(frame_g1), .remainder(rem1), .out_side()
  );

  // Layer 2: row and column, batch and frame
  logic             d3_valid;
  logic [DIV_W-1:0] h_out2, w_out2, b2, fo2, frame_g2;

  d2s_div_chain #(.SW(1)) u_div_row (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d1_valid), .dividend(rem1), .divisor({15'd0, cols_int}), .in_side(1'b0),
    .out_valid(), .quotient(h_out2), .remainder(w_out2), .out_side()
  );

  d2s_div_chain #(.SW(DIV_W)) u_div_batch (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d1_valid), .dividend(frame_g1), .divisor(frames_out), .in_side(frame_g1),
    .out_valid(d3_valid), .quotient(b2), .remainder(fo2), .out_side(frame_g2)
  );

  // Layer 3: source coordinates and sub-positions
  logic               d4_valid;
  logic [DIV_W-1:0]   t3, a3, h3, j3, w3, k3;
  logic [4*DIV_W-1:0] side3;

  d2s_div_chain #(.SW(4*DIV_W)) u_div_t (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d3_valid), .dividend(fo2 + SKIP_W), .divisor({28'd0, factor_t}),
    .in_side({b2, frame_g2, h_out2, w_out2}),
    .out_valid(d4_valid), .quotient(t3), .remainder(a3), .out_side(side3)
  );

  d2s_div_chain #(.SW(1)) u_div_h (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d3_valid), .dividend(h_out2), .divisor({28'd0, factor_h}), .in_side(1'b0),
    .out_valid(), .quotient(h3), .remainder(j3), .out_side()
  );

  d2s_div_chain #(.SW(1)) u_div_w (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d3_valid), .dividend(w_out2), .divisor({28'd0, factor_w}), .in_side(1'b0),
    .out_valid(), .quotient(w3), .remainder(k3), .out_side()
  );

  logic [DIV_W-1:0] b3, frame_g3, h_out3, w_out3;

  assign b3       = side3[4*DIV_W-1:3*DIV_W];
  assign frame_g3 = side3[3*DIV_W-1:2*DIV_W];
  assign h_out3   = side3[2*DIV_W-1:DIV_W];
  assign w_out3   = side3[DIV_W-1:0];

  // Address assembly, one multiply per path per stage
  logic               m1_valid, m2_valid, m3_valid;
  logic [DIV_W-1:0]   m1_p1, m1_t, m1_h, m1_w, m1_da, m1_db, m1_dc;
  logic [SLICE_W-1:0] m1_sl, m1_j, m1_k;
  logic [DIV_W-1:0]   m2_p2, m2_h, m2_w, m2_dst;
  logic [SLICE_W-1:0] m2_sl, m2_k;
  logic [DIV_W-1:0]   m3_p3, m3_w, m3_dst;
  logic [SLICE_W-1:0] m3_sl;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= d4_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_p1  <= DIV_W'(b3 * {21'd0, frames_in});
      m1_t   <= t3;
      m1_h   <= h3;
      m1_w   <= w3;
      m1_sl  <= SLICE_W'(a3[SLICE_W-1:0] * {5'd0, factor_h});
      m1_j   <= j3[SLICE_W-1:0];
      m1_k   <= k3[SLICE_W-1:0];
      m1_da  <= DIV_W'(frame_g3 * frame_pages);
      m1_db  <= DIV_W'(({25'd0, pad_rows} + h_out3) * {14'd0, cols_pad});
      m1_dc  <= {25'd0, pad_cols} + w_out3;

      m2_p2  <= DIV_W'((m1_p1 + m1_t) * {19'd0, rows_in});
      m2_h   <= m1_h;
      m2_w   <= m1_w;
      m2_sl  <= SLICE_W'((m1_sl + m1_j) * {5'd0, factor_w});
      m2_k   <= m1_k;
      m2_dst <= m1_da + m1_db + m1_dc;

      m3_p3  <= DIV_W'((m2_p2 + m2_h) * {19'd0, cols_in});
      m3_w   <= m2_w;
      m3_sl  <= m2_sl + m2_k;
      m3_dst <= m2_dst;
    end
  end

  logic [DIV_W-1:0]   res_src;
  logic [DIV_W-1:0]   skid_src, skid_dst;
  logic [SLICE_W-1:0] skid_sl;

  assign res_src = m3_p3 + m3_w;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || !out_stall) begin
      out_valid <= m3_valid;
    end else if (m3_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        source_page <= skid_src;
        slice_index <= skid_sl;
        dest_page   <= skid_dst;
      end
    end else if (!out_valid || !out_stall) begin
      source_page <= res_src;
      slice_index <= m3_sl;
      dest_page   <= m3_dst;
    end else begin
      skid_src <= res_src;
      skid_sl  <= m3_sl;
      skid_dst <= m3_dst;
    end
  end

  // Skid entry only fills behind a held output
  `D2S_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  // A stalled skid entry stays
  `D2S_ASSERT_NEXT(a_skid_holds, skid_valid && out_stall, skid_valid)
  // A taken skid entry drains into the output register in the next cycle
  `D2S_ASSERT_NEXT(a_skid_drains, skid_valid && !out_stall, !skid_valid && out_valid)
  // Output empties when taken with nothing behind it
  `D2S_ASSERT_NEXT(a_out_empties, out_valid && !out_stall && !skid_valid && !m3_valid, !out_valid)

endmodule

/* hw/rtl/d2s_div_cell.sv */
// ----------------------------------------------------------------------------
// d2s_div_cell
// One restoring-division step: resolves one quotient bit per cycle while en is high and
// hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module d2s_div_cell
  import d2s_pkg::*;
#(
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DIV_W-1:0] in_rem,
  input  logic [DIV_W-1:0] in_quo,
  input  logic [DIV_W-1:0] in_div,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [DIV_W-1:0] out_rem,
  output logic [DIV_W-1:0] out_quo,
  output logic [DIV_W-1:0] out_div,
  output logic [SW-1:0]    out_side
);

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;
  logic [DIV_W-1:0] rem_next;
  logic [DIV_W-1:0] quo_next;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial    = {in_rem, in_quo[DIV_W-1]};
    diff     = trial - {1'b0, in_div};
    fits     = (trial >= {1'b0, in_div});
    rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    quo_next = {in_quo[DIV_W-2:0], fits};
  end

  // Advance the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_quo  <= quo_next;
      out_div  <= in_div;
      out_side <= in_side;
    end
  end

endmodule

/* hw/rtl/d2s_div_chain.sv */
// ----------------------------------------------------------------------------
// d2s_div_chain
// Pipelined unsigned divider built from a row of one-bit cells. A zero
// divisor yields an all-ones quotient and the dividend as remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module d2s_div_chain
  import d2s_pkg::*;
#(
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder,
  output logic [SW-1:0]    out_side
);

  logic             v_w   [DIV_W+1];
  logic [DIV_W-1:0] rem_w [DIV_W+1];
  logic [DIV_W-1:0] quo_w [DIV_W+1];
  logic [DIV_W-1:0] div_w [DIV_W+1];
  logic [SW-1:0]    side_w[DIV_W+1];

  // Feed the head of the row
  assign v_w[0]    = in_valid;
  assign rem_w[0]  = '0;
  assign quo_w[0]  = dividend;
  assign div_w[0]  = divisor;
  assign side_w[0] = in_side;

  for (genvar i = 0; i < DIV_W; i++) begin : g_cell
    d2s_div_cell #(.SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v_w[i]),
      .in_rem   (rem_w[i]),
      .in_quo   (quo_w[i]),
      .in_div   (div_w[i]),
      .in_side  (side_w[i]),
      .out_valid(v_w[i+1]),
      .out_rem  (rem_w[i+1]),
      .out_quo  (quo_w[i+1]),
      .out_div  (div_w[i+1]),
      .out_side (side_w[i+1])
    );
  end

  // Take results from the tail of the row
  assign out_valid = v_w[DIV_W];
  assign quotient  = quo_w[DIV_W];
  assign remainder = rem_w[DIV_W];
  assign out_side  = side_w[DIV_W];

endmodule
